### sv/pslr_pkg.sv
// ----------------------------------------------------------------------------
// Per-slot publish rate limiter: shared definitions
// Slot count, time width, event and register codes, sequencer states and the
// control structs that pass between the sequencer, the slot store and the ALU.
// ----------------------------------------------------------------------------
package pslr_pkg;

  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned TIME_W = 32;

  localparam logic [TIME_W-1:0] MIN_INTERVAL_MS = TIME_W'(2000);

  typedef enum logic [1:0] {
    CMD_CONNECT    = 2'd0,
    CMD_FULL_QUERY = 2'd1,
    CMD_ITEM_QUERY = 2'd2,
    CMD_MARK_ALL   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_PUBLISH_INTERVAL = 2'd0,
    CFG_MIN_DELAY        = 2'd1,
    CFG_ON_CHANGE        = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CMP_IV,
    ST_CMP_MD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              clr_all;
    logic              set_all;
    logic              set_one;
    logic [SLOT_W-1:0] idx;
    logic [TIME_W-1:0] stamp;
  } store_cmd_t;

  typedef struct packed {
    logic              seen;
    logic [TIME_W-1:0] stamp;
  } slot_rd_t;

  typedef struct packed {
    logic              ge;
    logic [TIME_W-1:0] diff;
  } alu_res_t;

endpackage

### sv/pslr_alu.sv
// ----------------------------------------------------------------------------
// Shared subtract and compare unit
// One 33-bit subtractor: gives the wrapping difference a - b and a >= b.
// ----------------------------------------------------------------------------
module pslr_alu import pslr_pkg::*; (
  input  logic [TIME_W-1:0] a_i,
  input  logic [TIME_W-1:0] b_i,
  output alu_res_t          res_o
);

  logic [TIME_W:0] wide;

  // The top bit is the borrow, so its inverse is the unsigned a >= b.
  assign wide       = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff = wide[TIME_W-1:0];
  assign res_o.ge   = ~wide[TIME_W];

endmodule

### sv/pslr_slot_store.sv
// ----------------------------------------------------------------------------
// Slot store
// Seen bit and last report time for every slot, with one read port, a
// whole-store clear of the seen bits and whole-store and one-slot stamps.
// ----------------------------------------------------------------------------
module pslr_slot_store import pslr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  store_cmd_t        cmd_i,
  input  logic [SLOT_W-1:0] rd_idx_i,
  output slot_rd_t          rd_o
);

  logic [SLOTS-1:0]  seen_q, seen_d;
  logic [TIME_W-1:0] time_q [SLOTS];

  always_comb begin
    seen_d = seen_q;
    priority if (cmd_i.clr_all) begin
      seen_d = '0;
    end else if (cmd_i.set_all) begin
      seen_d = '1;
    end else if (cmd_i.set_one) begin
      seen_d[cmd_i.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

  // Times carry no reset: a time is only read once its slot has been seen,
  // and a slot is always stamped when it becomes seen.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SLOTS; k++) begin
      if (cmd_i.set_all || (cmd_i.set_one && cmd_i.idx == SLOT_W'(k))) begin
        time_q[k] <= cmd_i.stamp;
      end
    end
  end

  assign rd_o.seen  = seen_q[rd_idx_i];
  assign rd_o.stamp = time_q[rd_idx_i];

endmodule

### sv/pslr_seq.sv
// ----------------------------------------------------------------------------
// Event sequencer
// Takes one event word, steps the shared ALU through the elapsed-time
// subtract and the interval and delay compares as its command needs, then
// commits the state update and loads the result register.
// ----------------------------------------------------------------------------
module pslr_seq import pslr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // event side
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [1:0]        in_cmd_i,
  input  logic [7:0]        in_slot_i,
  input  logic              in_changed_i,
  input  logic [TIME_W-1:0] in_now_i,
  // result side
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic              m_grant_o,
  // effective settings
  input  logic              on_change_i,
  input  logic [TIME_W-1:0] eff_iv_i,
  input  logic [TIME_W-1:0] eff_md_i,
  // shared ALU
  output logic [TIME_W-1:0] alu_a_o,
  output logic [TIME_W-1:0] alu_b_o,
  input  alu_res_t          alu_i,
  // slot store
  output logic [SLOT_W-1:0] rd_idx_o,
  input  slot_rd_t          rd_i,
  output store_cmd_t        store_o
);

  state_e            state_q, state_d;
  cmd_e              cmd_q;
  logic [7:0]        slot_q;
  logic              changed_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] diff_q, diff_d;
  logic              grant_q, grant_d;
  logic              force_q, force_d;
  logic [TIME_W-1:0] last_full_q, last_full_d;
  logic              out_valid_q, out_valid_d;
  logic              out_grant_q, out_grant_d;
  logic              in_range;
  logic              accept;

  assign accept   = s_valid_i && s_ready_o;
  assign in_range = ({1'b0, slot_q} < 9'(SLOTS));
  assign rd_idx_o = slot_q[SLOT_W-1:0];

  always_comb begin
    state_d       = state_q;
    diff_d        = diff_q;
    grant_d       = grant_q;
    force_d       = force_q;
    last_full_d   = last_full_q;
    out_valid_d   = out_valid_q && !m_ready_i;
    out_grant_d   = out_grant_q;
    s_ready_o     = 1'b0;
    alu_a_o       = diff_q;
    alu_b_o       = eff_iv_i;
    store_o       = '0;
    store_o.idx   = slot_q[SLOT_W-1:0];
    store_o.stamp = now_q;

    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          grant_d = 1'b0;
          if (cmd_e'(in_cmd_i) == CMD_CONNECT || cmd_e'(in_cmd_i) == CMD_MARK_ALL) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_DIFF;
          end
        end
      end

      ST_DIFF: begin
        alu_a_o = now_q;
        alu_b_o = (cmd_q == CMD_FULL_QUERY) ? last_full_q : rd_i.stamp;
        diff_d  = alu_i.diff;
        priority if (cmd_q == CMD_FULL_QUERY) begin
          state_d = ST_CMP_IV;
        end else if (!on_change_i || !in_range) begin
          state_d = ST_DONE;
        end else if (!rd_i.seen) begin
          grant_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_CMP_IV;
        end
      end

      ST_CMP_IV: begin
        alu_a_o = diff_q;
        alu_b_o = eff_iv_i;
        if (cmd_q == CMD_FULL_QUERY) begin
          grant_d = force_q || alu_i.ge;
          state_d = ST_DONE;
        end else begin
          grant_d = alu_i.ge;
          state_d = ST_CMP_MD;
        end
      end

      ST_CMP_MD: begin
        alu_a_o = diff_q;
        alu_b_o = eff_md_i;
        grant_d = grant_q || (changed_q && alu_i.ge);
        state_d = ST_DONE;
      end

      ST_DONE: begin
        // Commit only once the result register is free, so no word is lost.
        if (!out_valid_q || m_ready_i) begin
          out_valid_d = 1'b1;
          out_grant_d = grant_q;
          state_d     = ST_IDLE;
          unique case (cmd_q)
            CMD_CONNECT: begin
              force_d         = 1'b1;
              store_o.clr_all = 1'b1;
            end
            CMD_FULL_QUERY: begin
              if (grant_q) begin
                force_d     = 1'b0;
                last_full_d = now_q;
              end
            end
            CMD_ITEM_QUERY: begin
              store_o.set_one = grant_q;
            end
            CMD_MARK_ALL: begin
              store_o.set_all = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grant_q     <= 1'b0;
      force_q     <= 1'b0;
      last_full_q <= '0;
      out_valid_q <= 1'b0;
      out_grant_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      grant_q     <= grant_d;
      force_q     <= force_d;
      last_full_q <= last_full_d;
      out_valid_q <= out_valid_d;
      out_grant_q <= out_grant_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_e'(in_cmd_i);
      slot_q    <= in_slot_i;
      changed_q <= in_changed_i;
      now_q     <= in_now_i;
    end
    diff_q <= diff_d;
  end

  assign m_valid_o = out_valid_q;
  assign m_grant_o = out_grant_q;

endmodule

### sv/per_slot_publish_rate_limiter_core.sv
// ----------------------------------------------------------------------------
// Per-slot publish rate limiter
// An event word steps through the sequencer: connect and mark-all go straight to
// the commit, refused or first-time item queries do the elapsed-time subtract
// first, a full query adds the interval compare and an item query on a seen slot
// adds the interval and delay compares; the shared ALU does one subtract or
// compare per cycle. A new word is taken only once the previous result is loaded.
// Reset sets control state, settings and seen bits to defaults; slot times are not reset.
// ----------------------------------------------------------------------------
module per_slot_publish_rate_limiter_core import pslr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // slot[7:0], changed[8], now_ms[40:9], zero fill
  input  logic [1:0]  s_axis_tuser_i,  // cmd[1:0]
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // grant[0], zero fill
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [TIME_W-1:0] interval_q;
  logic [TIME_W-1:0] min_delay_q;
  logic              on_change_q;
  logic [TIME_W-1:0] eff_iv_q, eff_iv_d;
  logic [TIME_W-1:0] eff_md_q, eff_md_d;
  logic [TIME_W-1:0] alu_a, alu_b;
  alu_res_t          alu_res;
  logic [SLOT_W-1:0] rd_idx;
  slot_rd_t          rd;
  store_cmd_t        store_cmd;
  logic              grant;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= MIN_INTERVAL_MS;
      min_delay_q <= '0;
      on_change_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PUBLISH_INTERVAL: interval_q  <= cfg_data_i;
        CFG_MIN_DELAY:        min_delay_q <= cfg_data_i;
        CFG_ON_CHANGE:        on_change_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // The clamped limits are registered in two steps, the interval and then the delay
  // clamped to it; the sequencer reads them only in its compare states.
  assign eff_iv_d = (interval_q < MIN_INTERVAL_MS) ? MIN_INTERVAL_MS : interval_q;
  assign eff_md_d = (min_delay_q > eff_iv_q) ? eff_iv_q : min_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_iv_q <= MIN_INTERVAL_MS;
      eff_md_q <= '0;
    end else begin
      eff_iv_q <= eff_iv_d;
      eff_md_q <= eff_md_d;
    end
  end

  pslr_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  pslr_slot_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (store_cmd),
    .rd_idx_i (rd_idx),
    .rd_o     (rd)
  );

  pslr_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .in_cmd_i     (s_axis_tuser_i),
    .in_slot_i    (s_axis_tdata_i[7:0]),
    .in_changed_i (s_axis_tdata_i[8]),
    .in_now_i     (s_axis_tdata_i[40:9]),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_grant_o    (grant),
    .on_change_i  (on_change_q),
    .eff_iv_i     (eff_iv_q),
    .eff_md_i     (eff_md_q),
    .alu_a_o      (alu_a),
    .alu_b_o      (alu_b),
    .alu_i        (alu_res),
    .rd_idx_o     (rd_idx),
    .rd_i         (rd),
    .store_o      (store_cmd)
  );

  assign m_axis_tdata_o = {7'b0, grant};

  // Accepting an event word takes the sequencer out of idle, which drops the event-side ready.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("event word taken while the previous one is still in work");

  a_interval_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eff_iv_q >= MIN_INTERVAL_MS)
    else $error("effective interval below the floor");

  a_delay_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $stable(eff_iv_q) |-> (eff_md_q <= eff_iv_q))
    else $error("effective minimum delay exceeds the effective interval");

endmodule
